// ----- src/fbr_pkg.sv -----
// shared types and constants for the rectangle raster engine
`timescale 1ns / 1ps
package fbr_pkg;

    localparam int MAX_WIDTH   = 320;
    localparam int MAX_HEIGHT  = 200;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int Y_W         = $clog2(MAX_HEIGHT);
    localparam int EW_W        = $clog2(MAX_WIDTH + 1);
    localparam int EH_W        = $clog2(MAX_HEIGHT + 1);

    localparam int COORD_W     = 16;
    localparam int PIX_W       = 8;
    localparam int SCR_W_W     = 9;
    localparam int SCR_H_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [SCR_W_W-1:0] SCR_W_RESET = 9'd320;
    localparam logic [SCR_H_W-1:0] SCR_H_RESET = 8'd200;

    localparam logic [PIX_W-1:0] LO_MASK     = 8'h0F;
    localparam logic [PIX_W-1:0] HI_MASK     = 8'hF0;
    localparam logic [4:0]       NIB_MAX     = 5'd15;
    localparam logic [4:0]       BRIGHT_STEP = 5'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        OP_PLOT     = 3'd0,
        OP_READ     = 3'd1,
        OP_OUTLINE  = 3'd2,
        OP_FILL     = 3'd3,
        OP_SHADE    = 3'd4,
        OP_BRIGHTEN = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WR,
        S_RD,
        S_MOD,
        S_DONE
    } t_state;

endpackage

// ----- src/fbr_cmd_if.sv -----
// command channel: valid, ready and the drawing request
`timescale 1ns / 1ps
interface fbr_cmd_if;
    logic                          valid;
    logic                          ready;
    fbr_pkg::t_op                  operation;
    logic [fbr_pkg::COORD_W-1:0]   left_x;
    logic [fbr_pkg::COORD_W-1:0]   top_y;
    logic [fbr_pkg::COORD_W-1:0]   right_x;
    logic [fbr_pkg::COORD_W-1:0]   bottom_y;
    logic [fbr_pkg::PIX_W-1:0]     color;

    modport source (
        output valid, operation, left_x, top_y, right_x, bottom_y, color,
        input  ready
    );
    modport sink (
        input  valid, operation, left_x, top_y, right_x, bottom_y, color,
        output ready
    );
endinterface

// ----- src/fbr_res_if.sv -----
// result channel: valid, ready, pixel value and status
`timescale 1ns / 1ps
interface fbr_res_if;
    logic                      valid;
    logic                      ready;
    logic [fbr_pkg::PIX_W-1:0] pixel_value;
    logic                      status;

    modport source (
        output valid, pixel_value, status,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, status,
        output ready
    );
endinterface

// ----- src/framebuffer_rect_raster_engine.sv -----
// rectangle raster engine over an 8-bit indexed frame store
// usage:
//   i_cmd carries one drawing request (operation, corners, color); o_res returns
//   exactly one result (pixel_value, status) per request, in order.
//   screen_width and screen_height are written through i_cfg_wr_en, i_cfg_index
//   and i_cfg_wdata while no request is in flight.
// operation:
//   one request at a time; the frame store is a single port ram, so each
//   pixel walk step is one write (plot, fill; outline writes edge pixels
//   only), one read (read) or one read plus one write (shade, brighten).
// reset:
//   synchronous, active low; afterwards a clearing pass writes zero to all
//   64000 store entries, one per cycle, and i_cmd.ready stays low meanwhile.
//   registers return to 320 by 200.
// stalls:
//   a finished result waits in the output register until o_res.ready; a later
//   result holds the engine in its done state, taking no new request, until then.
`timescale 1ns / 1ps
module framebuffer_rect_raster_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fbr_cmd_if.sink                         i_cmd,
    fbr_res_if.source                       o_res,
    input  logic                            i_cfg_wr_en,
    input  logic [fbr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import fbr_pkg::*;

    t_state r_state, n_state;

    logic [SCR_W_W-1:0] r_scr_w;
    logic [SCR_H_W-1:0] r_scr_h;
    logic [EW_W-1:0]    eff_w;
    logic [EH_W-1:0]    eff_h;

    t_op                r_op;
    logic [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [PIX_W-1:0]   r_color;

    logic [X_W-1:0]     r_walk_col;
    logic [Y_W-1:0]     r_walk_row;
    logic [X_W-1:0]     r_x_end;
    logic [Y_W-1:0]     r_y_end;
    logic [ADDR_W-1:0]  r_row_base;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic [PIX_W-1:0]   r_pix;
    logic               r_status;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pix;
    logic               r_out_status;

    logic               in1, in2, rect_ok, cmd_ok, is_rect, uses_rd;
    logic               walk_last, on_edge, clr_last, out_free;
    logic [Y_W+EW_W-1:0] base_prod;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIX_W-1:0]   ram_wdata;
    logic [PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]   mod_pix;
    logic [4:0]         bright_lo;

    // effective screen size
    assign eff_w = ({23'd0, r_scr_w} > 32'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH) : EW_W'(r_scr_w);
    assign eff_h = ({24'd0, r_scr_h} > 32'(MAX_HEIGHT)) ? EH_W'(MAX_HEIGHT) : EH_W'(r_scr_h);

    // request checks
    assign in1     = (r_x1 < COORD_W'(eff_w)) && (r_y1 < COORD_W'(eff_h));
    assign in2     = (r_x2 < COORD_W'(eff_w)) && (r_y2 < COORD_W'(eff_h));
    assign rect_ok = in1 && in2 && (r_x2 >= r_x1) && (r_y2 >= r_y1);

    always_comb begin
        unique case (r_op)
            OP_PLOT, OP_READ: begin
                cmd_ok  = in1;
                is_rect = 1'b0;
            end
            OP_OUTLINE, OP_FILL, OP_SHADE, OP_BRIGHTEN: begin
                cmd_ok  = rect_ok;
                is_rect = 1'b1;
            end
            default: begin
                cmd_ok  = 1'b0;
                is_rect = 1'b0;
            end
        endcase
    end

    assign uses_rd   = (r_op == OP_READ) || (r_op == OP_SHADE) || (r_op == OP_BRIGHTEN);
    assign base_prod = (Y_W+EW_W)'(r_y1[Y_W-1:0]) * (Y_W+EW_W)'(eff_w);

    // walker
    assign walk_last = (r_walk_col == r_x_end) && (r_walk_row == r_y_end);
    assign on_edge   = (r_walk_col == r_x1[X_W-1:0]) || (r_walk_col == r_x_end)
                    || (r_walk_row == r_y1[Y_W-1:0]) || (r_walk_row == r_y_end);
    assign clr_last  = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));
    assign out_free  = !r_out_valid || o_res.ready;

    // pixel modify
    assign bright_lo = {1'b0, ram_rdata[3:0]} + BRIGHT_STEP;
    always_comb begin
        if (r_op == OP_SHADE) begin
            mod_pix = ((ram_rdata & LO_MASK) >> 1) | (ram_rdata & HI_MASK);
        end else begin
            mod_pix = (ram_rdata & HI_MASK)
                    | {4'd0, ((bright_lo > NIB_MAX) ? NIB_MAX[3:0] : bright_lo[3:0])};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cmd.valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!cmd_ok) n_state = S_DONE;
                else if (uses_rd) n_state = S_RD;
                else n_state = S_WR;
            end
            S_WR: begin
                if (walk_last) n_state = S_DONE;
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                n_state = walk_last ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        i_cmd.ready = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_row_base + ADDR_W'(r_walk_col);
        ram_wdata   = r_color;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                i_cmd.ready = 1'b1;
            end
            S_WR: begin
                ram_we = (r_op != OP_OUTLINE) || on_edge;
            end
            S_MOD: begin
                ram_we    = (r_op != OP_READ);
                ram_wdata = mod_pix;
            end
            S_CHECK, S_RD, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    fbr_ram #(
        .DEPTH  (STORE_DEPTH),
        .WIDTH  (PIX_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_scr_w     <= SCR_W_RESET;
            r_scr_h     <= SCR_H_RESET;
            r_out_valid <= 1'b0;
            r_walk_col  <= '0;
            r_walk_row  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_wdata[SCR_W_W-1:0];
                    CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_wdata[SCR_H_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_CHECK) begin
                r_walk_col <= r_x1[X_W-1:0];
                r_walk_row <= r_y1[Y_W-1:0];
            end else if ((r_state == S_WR || r_state == S_MOD) && !walk_last) begin
                if (r_walk_col == r_x_end) begin
                    r_walk_col <= r_x1[X_W-1:0];
                    r_walk_row <= r_walk_row + Y_W'(1);
                end else begin
                    r_walk_col <= r_walk_col + X_W'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_op    <= i_cmd.operation;
            r_x1    <= i_cmd.left_x;
            r_y1    <= i_cmd.top_y;
            r_x2    <= i_cmd.right_x;
            r_y2    <= i_cmd.bottom_y;
            r_color <= i_cmd.color;
        end
        if (r_state == S_CHECK) begin
            r_row_base <= base_prod[ADDR_W-1:0];
            r_x_end    <= is_rect ? r_x2[X_W-1:0] : r_x1[X_W-1:0];
            r_y_end    <= is_rect ? r_y2[Y_W-1:0] : r_y1[Y_W-1:0];
            r_pix      <= '0;
            r_status   <= !cmd_ok;
        end else if ((r_state == S_WR || r_state == S_MOD) && !walk_last
                     && r_walk_col == r_x_end) begin
            r_row_base <= r_row_base + ADDR_W'(eff_w);
        end
        if (r_state == S_MOD && r_op == OP_READ) begin
            r_pix <= ram_rdata;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_pix    <= r_pix;
            r_out_status <= r_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.pixel_value = r_out_pix;
    assign o_res.status      = r_out_status;

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_CHECK))
        else $error("accepted request did not enter check");

    a_mod_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> ($past(r_state) == S_RD))
        else $error("modify step without a preceding read");

    a_walk_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR || r_state == S_MOD)
            |-> (r_walk_col <= r_x_end && r_walk_row <= r_y_end))
        else $error("walker left the rectangle");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_CHECK) |-> !ram_we)
        else $error("store written outside a walk or clear");
`endif
endmodule

// ----- src/fbr_ram.sv -----
// single port synchronous ram, registered read, read before write
`timescale 1ns / 1ps
module fbr_ram #(
    parameter int DEPTH  = 64000,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
